// File: hdl/difc_pkg.sv
package difc_pkg;

	typedef enum logic [1:0] {
		MODE_AWAKE  = 2'd0,
		MODE_FOUT   = 2'd1,
		MODE_ASLEEP = 2'd2,
		MODE_FIN    = 2'd3
	} mode_t;

	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_ACT   = 2'd1;
	localparam logic [1:0] KIND_PRESS = 2'd2;
	localparam logic [1:0] KIND_FORCE = 2'd3;

	localparam logic [2:0] REG_DEF_BRIGHT = 3'd0;
	localparam logic [2:0] REG_IDLE_TO    = 3'd1;
	localparam logic [2:0] REG_FADE_STEP  = 3'd2;
	localparam logic [2:0] REG_FADE_OUT   = 3'd3;
	localparam logic [2:0] REG_FADE_IN    = 3'd4;
	localparam logic [2:0] REG_SLEEP_CHG  = 3'd5;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 22;
	localparam int IN_TDATA_W = 56;
	localparam int OUT_TDATA_W = 16;

	localparam logic [7:0]  RST_DEF_BRIGHT = 8'd255;
	localparam logic [21:0] RST_IDLE_TO    = 22'd30000;
	localparam logic [9:0]  RST_FADE_STEP  = 10'd20;
	localparam logic [15:0] RST_FADE_OUT   = 16'd1000;
	localparam logic [15:0] RST_FADE_IN    = 16'd300;

	localparam logic [21:0] WAKE_MIN   = 22'd1000;
	localparam logic [21:0] WAKE_MAX   = 22'd3600000;
	localparam logic [21:0] WAKE_RESET = 22'd300000;
	localparam logic [7:0]  BRIGHT_MAX = 8'd255;

	// Interpolation product is an 8-bit span magnitude times a 16-bit elapsed time.
	localparam int DIV_BITS = 24;
	localparam int DIV_CW   = 5;

	typedef struct packed {
		logic load_in;
		logic prep;
		logic step;
		logic mul;
		logic div;
		logic fix;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic need_div;
	} status_t;

	function automatic logic is_dark(mode_t m);
		return (m == MODE_FOUT) || (m == MODE_ASLEEP);
	endfunction

endpackage

// File: hdl/difc_ctrl.sv
module difc_ctrl import difc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	output logic    m_tvalid,
	input  logic    m_tready,
	input  status_t sts,
	output cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_STEP,
		ST_MUL,
		ST_DIV,
		ST_FIX,
		ST_OUT
	} state_t;

	state_t state_q;
	logic [DIV_CW-1:0] cnt_q;
	logic m_tvalid_q;
	logic out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: cmd.load_in  = s_tvalid;
			ST_PREP: cmd.prep     = 1'b1;
			ST_STEP: cmd.step     = 1'b1;
			ST_MUL:  cmd.mul      = 1'b1;
			ST_DIV:  cmd.div      = 1'b1;
			ST_FIX:  cmd.fix      = 1'b1;
			ST_OUT:  cmd.load_out = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// A new result may replace the one taken in the same cycle.
			if (state_q == ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: state_q <= ST_STEP;
				ST_STEP: begin
					state_q <= sts.need_div ? ST_MUL : ST_OUT;
				end
				ST_MUL: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_CW'(DIV_BITS - 1)) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: hdl/difc_datapath.sv
module difc_datapath import difc_pkg::*; #(
	parameter int TIME_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic [1:0]             s_tuser,
	input  cmd_t                   cmd,
	output status_t                sts,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic [0:0]             m_tuser
);

	localparam int CW = (TIME_BITS > 22) ? TIME_BITS : 22;

	// Configuration
	logic [7:0]  def_q;
	logic [21:0] idle_q;
	logic [9:0]  step_q;
	logic [15:0] fout_q;
	logic [15:0] fin_q;
	logic        swc_q;

	// Controller state
	mode_t                mode_q;
	logic [TIME_BITS-1:0] la_q, fstart_q, flast_q, wu_q;
	logic [7:0]           src_q, tgt_q;
	logic                 frc_q, win_q;
	logic [21:0]          wl_q;

	// Latched item
	logic [1:0]           kind_q;
	logic [TIME_BITS-1:0] now_q;
	logic                 vbus_q, force_q;
	logic [21:0]          wlen_q;

	// Differences taken ahead of the decision cycle
	logic                 fnow_s1;
	logic [TIME_BITS-1:0] dact_s1, dstep_s1, dstart_s1, wsum_s1;

	// Working result and interpolation operands
	logic        wr_q, cons_q;
	logic [7:0]  br_q;
	logic [15:0] el_q, dur_q;
	logic [7:0]  mag_q;
	logic        neg_q;
	logic [DIV_BITS-1:0] dvd_q;
	logic [15:0] rem_q;

	// Output register
	logic       out_wr_q, out_cons_q, out_asleep_q, out_forced_q;
	logic [7:0] out_br_q;

	logic [TIME_BITS-1:0] fdiff;
	logic                 fcur;

	// Forced sleep holds unless an armed wake window has not yet run out.
	assign fdiff = now_q - wu_q;
	assign fcur  = frc_q && (!win_q || !fdiff[TIME_BITS-1]);

	mode_t                n_mode;
	logic [7:0]           n_src, n_tgt, n_br;
	logic                 restart, touch, stepped, n_wr, n_cons, div_req;
	logic [TIME_BITS-1:0] n_wu, ds, el, dact;
	logic                 n_win, n_frc;
	logic [21:0]          n_wl;
	logic [15:0]          dur;

	always_comb begin
		n_mode  = mode_q;
		n_src   = src_q;
		n_tgt   = tgt_q;
		n_br    = '0;
		restart = 1'b0;
		touch   = 1'b0;
		stepped = 1'b0;
		n_wr    = 1'b0;
		n_cons  = 1'b0;
		div_req = 1'b0;
		n_wu    = wu_q;
		n_win   = win_q;
		n_frc   = frc_q;
		n_wl    = wl_q;
		ds      = '0;
		el      = '0;
		dact    = '0;
		dur     = '0;
		case (kind_q)
			KIND_TICK: begin
				if (fnow_s1 && (n_mode == MODE_AWAKE || n_mode == MODE_FIN)) begin
					n_src   = def_q;
					n_tgt   = '0;
					restart = 1'b1;
					n_mode  = MODE_FOUT;
				end
				if (!fnow_s1 && !swc_q && vbus_q) begin
					touch = 1'b1;
					if (is_dark(n_mode)) begin
						n_src   = '0;
						n_tgt   = def_q;
						restart = 1'b1;
						n_mode  = MODE_FIN;
					end
				end
				ds   = restart ? '0 : dstep_s1;
				el   = restart ? '0 : dstart_s1;
				dact = touch ? '0 : dact_s1;
				dur  = (n_mode == MODE_FOUT) ? fout_q : fin_q;
				if (n_mode == MODE_AWAKE) begin
					if (!fnow_s1 && CW'(dact) >= CW'(idle_q)) begin
						n_src   = def_q;
						n_tgt   = '0;
						restart = 1'b1;
						n_mode  = MODE_FOUT;
					end
				end else if (n_mode == MODE_FOUT || n_mode == MODE_FIN) begin
					if (ds >= TIME_BITS'(step_q)) begin
						stepped = 1'b1;
						n_wr    = 1'b1;
						if (el >= TIME_BITS'(dur)) begin
							n_br   = n_tgt;
							n_mode = (n_mode == MODE_FOUT) ? MODE_ASLEEP : MODE_AWAKE;
						end else begin
							div_req = 1'b1;
						end
					end
				end
			end
			KIND_ACT: begin
				touch = 1'b1;
				if (is_dark(mode_q)) begin
					n_src   = '0;
					n_tgt   = def_q;
					restart = 1'b1;
					n_mode  = MODE_FIN;
				end
			end
			KIND_PRESS: begin
				touch = 1'b1;
				if (is_dark(mode_q)) begin
					if (frc_q) begin
						n_wu  = wsum_s1;
						n_win = 1'b1;
					end
					n_src   = '0;
					n_tgt   = def_q;
					restart = 1'b1;
					n_mode  = MODE_FIN;
					n_cons  = 1'b1;
				end else if (mode_q == MODE_FIN) begin
					n_cons = 1'b1;
				end
			end
			KIND_FORCE: begin
				if (wlen_q < WAKE_MIN) begin
					n_wl = WAKE_MIN;
				end else if (wlen_q > WAKE_MAX) begin
					n_wl = WAKE_MAX;
				end else begin
					n_wl = wlen_q;
				end
				if (force_q) begin
					n_frc = 1'b1;
				end else begin
					n_frc = 1'b0;
					n_wu  = '0;
					n_win = 1'b0;
					if (frc_q && is_dark(mode_q)) begin
						touch   = 1'b1;
						n_src   = '0;
						n_tgt   = def_q;
						restart = 1'b1;
						n_mode  = MODE_FIN;
					end
				end
			end
			default: n_mode = mode_q;
		endcase
	end

	assign sts.need_div = div_req;

	logic [16:0] rem_sh;
	logic signed [9:0] bsum;

	assign rem_sh = {rem_q, dvd_q[DIV_BITS-1]};
	assign bsum   = neg_q ? ($signed({2'b00, src_q}) - $signed({2'b00, dvd_q[7:0]}))
	                      : ($signed({2'b00, src_q}) + $signed({2'b00, dvd_q[7:0]}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_q    <= RST_DEF_BRIGHT;
			idle_q   <= RST_IDLE_TO;
			step_q   <= RST_FADE_STEP;
			fout_q   <= RST_FADE_OUT;
			fin_q    <= RST_FADE_IN;
			swc_q    <= 1'b0;
			mode_q   <= MODE_AWAKE;
			la_q     <= '0;
			fstart_q <= '0;
			flast_q  <= '0;
			src_q    <= RST_DEF_BRIGHT;
			tgt_q    <= '0;
			frc_q    <= 1'b0;
			wl_q     <= WAKE_RESET;
			wu_q     <= '0;
			win_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DEF_BRIGHT: def_q  <= cfg_data[7:0];
					REG_IDLE_TO:    idle_q <= cfg_data[21:0];
					REG_FADE_STEP:  step_q <= cfg_data[9:0];
					REG_FADE_OUT:   fout_q <= cfg_data[15:0];
					REG_FADE_IN:    fin_q  <= cfg_data[15:0];
					REG_SLEEP_CHG:  swc_q  <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.step) begin
				mode_q <= n_mode;
				src_q  <= n_src;
				tgt_q  <= n_tgt;
				frc_q  <= n_frc;
				wl_q   <= n_wl;
				wu_q   <= n_wu;
				win_q  <= n_win;
				if (touch) begin
					la_q <= now_q;
				end
				if (restart) begin
					fstart_q <= now_q;
				end
				if (restart || stepped) begin
					flast_q <= now_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_q  <= s_tuser;
			now_q   <= s_tdata[TIME_BITS-1:0];
			vbus_q  <= s_tdata[32];
			force_q <= s_tdata[33];
			wlen_q  <= s_tdata[55:34];
		end
		if (cmd.prep) begin
			fnow_s1   <= fcur;
			dact_s1   <= now_q - la_q;
			dstep_s1  <= now_q - flast_q;
			dstart_s1 <= now_q - fstart_q;
			wsum_s1   <= TIME_BITS'(CW'(now_q) + CW'(wl_q));
		end
		if (cmd.step) begin
			wr_q   <= n_wr;
			br_q   <= n_br;
			cons_q <= n_cons;
			el_q   <= el[15:0];
			dur_q  <= dur;
			neg_q  <= (n_tgt < n_src);
			mag_q  <= (n_tgt < n_src) ? (n_src - n_tgt) : (n_tgt - n_src);
		end
		if (cmd.mul) begin
			dvd_q <= DIV_BITS'(mag_q) * DIV_BITS'(el_q);
			rem_q <= '0;
		end
		if (cmd.div) begin
			// One restoring step: the quotient bit shifts in where the dividend leaves.
			if (rem_sh >= {1'b0, dur_q}) begin
				rem_q <= 16'(rem_sh - {1'b0, dur_q});
				dvd_q <= {dvd_q[DIV_BITS-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[15:0];
				dvd_q <= {dvd_q[DIV_BITS-2:0], 1'b0};
			end
		end
		if (cmd.fix) begin
			if (bsum < 0) begin
				br_q <= '0;
			end else if (bsum > $signed({2'b00, BRIGHT_MAX})) begin
				br_q <= BRIGHT_MAX;
			end else begin
				br_q <= bsum[7:0];
			end
		end
		if (cmd.load_out) begin
			out_wr_q     <= wr_q;
			out_br_q     <= br_q;
			out_cons_q   <= cons_q;
			out_asleep_q <= is_dark(mode_q);
			out_forced_q <= fcur;
		end
	end

	assign m_tdata = {5'b0, out_forced_q, out_asleep_q, out_cons_q, out_br_q};
	assign m_tuser = out_wr_q;

endmodule

// File: hdl/display_idle_fade_controller.sv
// Display idle controller: tracks awake, fading out, asleep and fading in, and returns one
// result item for every input item. After the decision, an item with no interpolation goes
// to the output register; a tick that interpolates a fade first runs a 24-step restoring
// divider. One item is in work at a time; the next one is accepted in the cycle after the
// result is loaded into the output register, even while it still waits for m_tready.
// Configuration is to be written through cfg_we, cfg_index and cfg_data only while no item
// is in work; the block does not enforce this. Timestamps wrap modulo 2^TIME_BITS.
module display_idle_fade_controller import difc_pkg::*; #(
	parameter int TIME_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // now_ms[31:0], vbus_in, force_on, wake_len_ms[21:0]
	input  logic [1:0]             s_tuser,  // kind
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // brightness[7:0], press_consumed, asleep,
	                                         // forced_active, zero fill
	output logic [0:0]             m_tuser   // bright_write
);

	cmd_t    cmd;
	status_t sts;

	difc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	difc_datapath #(
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd       (cmd),
		.sts       (sts),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

// File: hdl/difc_checker.sv
module difc_checker import difc_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic [0:0]             m_tuser
);

	// A pending result stays offered until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped before it was taken");

	// Only one item is in work: acceptance closes the input until the result is built.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item accepted while one is in work");

	// Brightness reads zero whenever no write is driven.
	a_br_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'd0)
		else $error("brightness nonzero without a write");

	// A brightness write comes from a tick, a swallowed press from a wake press.
	a_wr_cons: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tdata[8]))
		else $error("write and swallowed press in one item");

endmodule

bind display_idle_fade_controller difc_checker u_difc_checker (.*);
